FILE: hdl/ssrch_pkg.sv
// ----------------------------------------------------------------------------
// Substring search package
// Shared widths, register addresses, parameter defaults and the
// configuration bundle handed from the register block to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssrch_pkg;

   // field widths fixed by the interface
   localparam int ByteW   = 8;
   localparam int LenW    = 4;
   localparam int OffsetW = 16;

   // register port
   localparam int CsrDataW = 64;
   localparam int CsrAddrW = 4;

   // register select (bit 3 of the byte address, registers are 8 bytes apart)
   localparam logic RegPatternBytes  = 1'b0;
   localparam logic RegPatternLength = 1'b1;

   // parameter defaults
   localparam int MaxPatternDefault   = 8;
   localparam int PositionBitsDefault = 16;

   // configuration seen by the datapath
   typedef struct packed {
      logic [CsrDataW-1:0] pattern_bytes;
      logic [LenW-1:0]     pattern_length;
   } cfg_type;

endpackage

FILE: hdl/substring_search.sv
// ----------------------------------------------------------------------------
// Substring search
// Streams a zero-terminated text one byte per transaction and reports the
// first place where the configured pattern of up to MAX_PATTERN bytes starts.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while req_stall is low; the window cells compare in parallel.
// The result of a text is registered and is on rsp_ in the cycle after its zero byte is accepted.
// A waiting result stalls the input only while rsp_stall is high.
// Reset clears the registers, window, counter and result valid flag; the result fields are not reset.
`timescale 1ns / 1ps

module substring_search #(
   parameter int MAX_PATTERN   = ssrch_pkg::MaxPatternDefault,
   parameter int POSITION_BITS = ssrch_pkg::PositionBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // text bytes
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ssrch_pkg::ByteW-1:0]    req_text_byte,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [ssrch_pkg::OffsetW-1:0]  rsp_match_offset,
   output logic                          rsp_length_overflow,
   // registers
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ssrch_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [ssrch_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [ssrch_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int CntW = POSITION_BITS + 1;
   localparam int ExtW = POSITION_BITS + ssrch_pkg::OffsetW;
   localparam logic [ssrch_pkg::LenW-1:0] MaxLen = ssrch_pkg::LenW'(MAX_PATTERN);

   ssrch_pkg::cfg_type cfg;

   logic                            accept;
   logic                            accept_byte;
   logic                            accept_end;
   logic [ssrch_pkg::LenW-1:0]      used_len;
   logic                            len_zero;
   logic [ssrch_pkg::ByteW-1:0]     window [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]          hits;
   logic                            all_hit;

   logic [CntW-1:0]                 count_ff;
   logic [CntW-1:0]                 count_in;
   logic [CntW-1:0]                 count_plus;
   logic [CntW-1:0]                 start_diff;
   logic                            saturated;
   logic                            match_now;
   logic                            match_seen_ff;
   logic                            match_seen_in;
   logic [POSITION_BITS-1:0]        start_ff;
   logic [POSITION_BITS-1:0]        start_in;
   logic                            overflow_seen_ff;
   logic                            overflow_seen_in;
   logic [ExtW-1:0]                 start_ext;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            found_ff;
   logic                            found_in;
   logic [ssrch_pkg::OffsetW-1:0]   offset_ff;
   logic [ssrch_pkg::OffsetW-1:0]   offset_in;
   logic                            overflow_ff;
   logic                            overflow_in;

   ssrch_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: a held result blocks the input only while it is stalled
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign accept_end  = accept && (req_text_byte == '0);
   assign accept_byte = accept && (req_text_byte != '0);

   // pattern length clipped to the window size
   assign used_len = (cfg.pattern_length > MaxLen) ? MaxLen : cfg.pattern_length;
   assign len_zero = (used_len == '0);

   // window cells, cell 0 takes the newest byte
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [ssrch_pkg::ByteW-1:0] cell_in;
      logic [ssrch_pkg::LenW-1:0]  pat_idx;
      logic                        cell_en;

      if (k == 0) begin : g_head
         assign cell_in = req_text_byte;
      end else begin : g_link
         assign cell_in = window[k-1];
      end

      // cell k lines up with pattern character used_len-1-k
      assign cell_en = (ssrch_pkg::LenW'(k) < used_len);
      assign pat_idx = used_len - ssrch_pkg::LenW'(k + 1);

      ssrch_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .shift_en     (accept_byte),
         .clear        (accept_end),
         .enable       (cell_en),
         .byte_in      (cell_in),
         .pattern_byte (cfg.pattern_bytes[ssrch_pkg::ByteW*pat_idx[2:0] +: ssrch_pkg::ByteW]),
         .byte_out     (window[k]),
         .hit          (hits[k])
      );
   end

   assign all_hit = &hits;

   // position tracking and first match
   assign saturated  = count_ff[POSITION_BITS];
   assign count_plus = count_ff + CntW'(1);
   assign start_diff = count_plus - CntW'(used_len);
   assign match_now  = !match_seen_ff && !len_zero && all_hit &&
                       (count_plus >= CntW'(used_len));

   always_comb begin
      count_in         = count_ff;
      match_seen_in    = match_seen_ff;
      start_in         = start_ff;
      overflow_seen_in = overflow_seen_ff;
      priority if (accept_end) begin
         count_in         = '0;
         match_seen_in    = 1'b0;
         start_in         = '0;
         overflow_seen_in = 1'b0;
      end else if (accept_byte) begin
         if (saturated) begin
            overflow_seen_in = 1'b1;
         end else begin
            count_in = count_plus;
            if (match_now) begin
               match_seen_in = 1'b1;
               start_in      = start_diff[POSITION_BITS-1:0];
            end
         end
      end
   end

   // result slot
   assign start_ext = ExtW'(start_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      offset_in    = offset_ff;
      overflow_in  = overflow_ff;
      if (accept_end) begin
         rsp_valid_in = 1'b1;
         found_in     = match_seen_ff || len_zero;
         offset_in    = (match_seen_ff && !len_zero) ?
                        start_ext[ssrch_pkg::OffsetW-1:0] : '0;
         overflow_in  = overflow_seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         match_seen_ff    <= 1'b0;
         start_ff         <= '0;
         overflow_seen_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         match_seen_ff    <= match_seen_in;
         start_ff         <= start_in;
         overflow_seen_ff <= overflow_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      offset_ff   <= offset_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_match_offset    = offset_ff;
   assign rsp_length_overflow = overflow_ff;

endmodule

FILE: hdl/ssrch_cell.sv
// ----------------------------------------------------------------------------
// Substring search window cell
// Holds one byte of the text window, passes it to the next cell on every
// accepted byte and compares the byte it takes in with its pattern byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrch_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic                       clear,
   input  logic                       enable,
   input  logic [ssrch_pkg::ByteW-1:0] byte_in,
   input  logic [ssrch_pkg::ByteW-1:0] pattern_byte,
   output logic [ssrch_pkg::ByteW-1:0] byte_out,
   output logic                       hit
);

   logic [ssrch_pkg::ByteW-1:0] data_ff;
   logic [ssrch_pkg::ByteW-1:0] data_in;

   // next window byte
   always_comb begin
      priority if (clear) begin
         data_in = '0;
      end else if (shift_en) begin
         data_in = byte_in;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   // compare the incoming byte, cells past the pattern length always agree
   assign hit      = !enable || (byte_in == pattern_byte);
   assign byte_out = data_ff;

endmodule

FILE: hdl/ssrch_csr.sv
// ----------------------------------------------------------------------------
// Substring search register block
// APB-style access to the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrch_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ssrch_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [ssrch_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [ssrch_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready,
   output ssrch_pkg::cfg_type            cfg
);

   logic [ssrch_pkg::CsrDataW-1:0] pattern_bytes_ff;
   logic [ssrch_pkg::CsrDataW-1:0] pattern_bytes_in;
   logic [ssrch_pkg::LenW-1:0]     pattern_length_ff;
   logic [ssrch_pkg::LenW-1:0]     pattern_length_in;
   logic                           wr_en;
   logic                           reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3];

   // register write
   always_comb begin
      pattern_bytes_in  = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ssrch_pkg::RegPatternBytes: begin
               pattern_bytes_in = csr_pwdata;
            end
            ssrch_pkg::RegPatternLength: begin
               pattern_length_in = csr_pwdata[ssrch_pkg::LenW-1:0];
            end
            default: begin
               pattern_bytes_in = pattern_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
      end else begin
         pattern_bytes_ff  <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   // register read
   always_comb begin
      unique case (reg_sel)
         ssrch_pkg::RegPatternBytes:  csr_prdata = pattern_bytes_ff;
         ssrch_pkg::RegPatternLength: csr_prdata = ssrch_pkg::CsrDataW'(pattern_length_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.pattern_bytes  = pattern_bytes_ff;
   assign cfg.pattern_length = pattern_length_ff;

endmodule

FILE: hdl/ssrch_checker.sv
// ----------------------------------------------------------------------------
// Substring search port checker
// Watches the top-level ports for result ordering and handshake slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrch_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [ssrch_pkg::ByteW-1:0]    req_text_byte,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic [ssrch_pkg::OffsetW-1:0]  rsp_match_offset,
   input logic                          rsp_length_overflow
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_match_offset) && $stable(rsp_length_overflow))
      else $error("stalled result changed");

   // a terminator transaction yields a result in the next cycle
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_text_byte == '0 |=> rsp_valid)
      else $error("no result after terminator");

   // ordinary bytes never invent a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && req_text_byte != '0 |=> !rsp_valid)
      else $error("result without terminator");

   // a miss reports offset zero
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("nonzero offset on miss");

endmodule

bind substring_search ssrch_checker u_ssrch_checker (.*);
